@@ rtl/coalescing_delta_queue_macros.svh @@
// Assertion macros for the coalescing delta queue.
`ifndef COALESCING_DELTA_QUEUE_MACROS_SVH
`define COALESCING_DELTA_QUEUE_MACROS_SVH

`ifndef SYNTH
`define CDQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CDQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/cdq_pkg.sv @@
`timescale 1ns / 1ps
package cdq_pkg;
   localparam int QUEUE_DEPTH = 32;
   localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 32;
   localparam int DELTA_W     = 32;
   localparam int ACTION_W    = 2;

   localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;

   typedef struct packed {
      logic                      hit;
      logic                      zero;
      logic signed [DELTA_W-1:0] sum;
   } merge_result_type;

   function automatic logic signed [DELTA_W-1:0] unit_delta(input logic release_op);
      unit_delta = release_op ? DELTA_W'(1) : -DELTA_W'(1);
   endfunction
endpackage

@@ rtl/cdq_ram.sv @@
`timescale 1ns / 1ps
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/cdq_merge.sv @@
`timescale 1ns / 1ps
module cdq_merge (
   input  logic [cdq_pkg::ID_W-1:0]           entry_id,
   input  logic signed [cdq_pkg::DELTA_W-1:0] entry_delta,
   input  logic [cdq_pkg::ID_W-1:0]           new_id,
   input  logic                               release_op,
   output cdq_pkg::merge_result_type          result
);
   import cdq_pkg::*;

   logic signed [DELTA_W:0] sum_wide;

   always_comb begin
      sum_wide = {entry_delta[DELTA_W-1], entry_delta}
               + {{1{release_op ? 1'b0 : 1'b1}}, unit_delta(release_op)};
      result.hit = (entry_id == new_id);
      if (sum_wide[DELTA_W] != sum_wide[DELTA_W-1]) begin
         // saturate
         result.sum = sum_wide[DELTA_W] ? {1'b1, {(DELTA_W-1){1'b0}}}
                                        : {1'b0, {(DELTA_W-1){1'b1}}};
      end else begin
         result.sum = sum_wide[DELTA_W-1:0];
      end
      result.zero = (sum_wide == '0);
   end
endmodule

@@ rtl/coalescing_delta_queue.sv @@
`timescale 1ns / 1ps
// Coalescing queue of reference-count adjustments.
// Input: req_action / req_object_id transfer when start is high and busy low.
//   Acquire adds -1, release +1 to the newest entry if the id matches, else
//   appends; tick flushes the queue; ids at or below csr limit are dropped.
// Config: csr_data is written on csr_valid (csr_ready is always high);
//   write it only while the block is idle.
// Output: each flushed entry is shown for one cycle with rsp_valid,
//   oldest first; rsp_last_of_flush marks the final one. No backpressure.
// Timing: entries live in a RAM with a registered read. An append to an
//   empty queue, a dropped id, an unused action or a tick on an empty queue
//   leaves busy low; any other acquire/release reads the newest entry, then
//   writes back. A tick, or an append that misses on a full queue, keeps busy
//   high while the flush runs; each result trails its RAM read data by one
//   output register.
// Reset: empties the queue, clears the limit to 0; no RAM clearing pass.
module coalescing_delta_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [cdq_pkg::ACTION_W-1:0]       req_action,
   input  logic [cdq_pkg::ID_W-1:0]           req_object_id,
   output logic                               rsp_valid,
   output logic [cdq_pkg::ID_W-1:0]           rsp_flushed_id,
   output logic signed [cdq_pkg::DELTA_W-1:0] rsp_flushed_delta,
   output logic                               rsp_last_of_flush,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cdq_pkg::ID_W-1:0]           csr_data
);
   import cdq_pkg::*;
   `include "coalescing_delta_queue_macros.svh"

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [COUNT_W-1:0] fill_count_ff, fill_count_in;
   logic [COUNT_W-1:0] drain_idx_ff, drain_idx_in;
   logic               append_ff, append_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic               release_ff, release_in;
   logic [ID_W-1:0]    limit_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]           rsp_id_ff, rsp_id_in;
   logic signed [DELTA_W-1:0] rsp_delta_ff, rsp_delta_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      wr_en, rd_en;
   logic [ADDR_W-1:0]         wr_addr, rd_addr;
   logic [ID_W-1:0]           wr_id, rd_id;
   logic signed [DELTA_W-1:0] wr_delta, rd_delta;
   logic [COUNT_W-1:0]        tail_idx;
   logic                      drain_last;
   merge_result_type          merge;

   cdq_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_id_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_id),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_id)
   );

   cdq_ram #(.WIDTH(DELTA_W), .DEPTH(QUEUE_DEPTH)) u_delta_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_delta),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_delta)
   );

   cdq_merge u_merge (
      .entry_id    (rd_id),
      .entry_delta (rd_delta),
      .new_id      (id_ff),
      .release_op  (release_ff),
      .result      (merge)
   );

   assign tail_idx   = fill_count_ff - COUNT_W'(1);
   assign drain_last = (drain_idx_ff == fill_count_ff);

   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      drain_idx_in  = drain_idx_ff;
      append_in     = append_ff;
      id_in         = id_ff;
      release_in    = release_ff;
      rsp_valid_in  = 1'b0;
      rsp_id_in     = rd_id;
      rsp_delta_in  = rd_delta;
      rsp_last_in   = drain_last;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_id         = id_ff;
      wr_delta      = unit_delta(release_ff);
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_action) inside
                  ACT_TICK: begin
                     if (fill_count_ff != '0) begin
                        rd_en        = 1'b1;
                        drain_idx_in = COUNT_W'(1);
                        append_in    = 1'b0;
                        state_in     = ST_DRAIN;
                     end
                  end
                  ACT_ACQUIRE, ACT_RELEASE: begin
                     if (req_object_id > limit_ff) begin
                        id_in      = req_object_id;
                        release_in = (req_action == ACT_RELEASE);
                        if (fill_count_ff == '0) begin
                           wr_en         = 1'b1;
                           wr_id         = req_object_id;
                           wr_delta      = unit_delta(req_action == ACT_RELEASE);
                           fill_count_in = COUNT_W'(1);
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = tail_idx[ADDR_W-1:0];
                           state_in = ST_LOOKUP;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if (merge.hit) begin
               if (merge.zero) begin
                  fill_count_in = tail_idx;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_idx[ADDR_W-1:0];
                  wr_delta = merge.sum;
               end
               state_in = ST_IDLE;
            end else if (fill_count_ff == COUNT_W'(QUEUE_DEPTH)) begin
               rd_en        = 1'b1;
               drain_idx_in = COUNT_W'(1);
               append_in    = 1'b1;
               state_in     = ST_DRAIN;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = fill_count_ff[ADDR_W-1:0];
               fill_count_in = fill_count_ff + COUNT_W'(1);
               state_in      = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            rsp_valid_in = 1'b1;
            if (drain_last) begin
               if (append_ff) begin
                  wr_en         = 1'b1;
                  fill_count_in = COUNT_W'(1);
               end else begin
                  fill_count_in = '0;
               end
               state_in = ST_IDLE;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = drain_idx_ff[ADDR_W-1:0];
               drain_idx_in = drain_idx_ff + COUNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_count_ff <= '0;
         drain_idx_ff  <= '0;
         append_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         limit_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         drain_idx_ff  <= drain_idx_in;
         append_ff     <= append_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      release_ff   <= release_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_delta_ff <= rsp_delta_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flushed_id    = rsp_id_ff;
   assign rsp_flushed_delta = rsp_delta_ff;
   assign rsp_last_of_flush = rsp_last_ff;

   // a flush transfers one entry per cycle until its last
   `CDQ_ASSERT_NEXT(a_drain_contiguous, clock, reset, rsp_valid_ff && !rsp_last_ff, rsp_valid_ff)
   // after the last entry the queue holds at most the pending append
   `CDQ_ASSERT_SAME(a_flush_empties, clock, reset, rsp_valid_ff && rsp_last_ff, fill_count_ff <= COUNT_W'(1))
   `CDQ_ASSERT_SAME(a_count_bound, clock, reset, busy, fill_count_ff <= COUNT_W'(QUEUE_DEPTH))
endmodule
